/* sv/cylinder_point_projection_assert.svh */
// Assertion macros shared by the cylinder point projection RTL.
`ifndef CYLINDER_POINT_PROJECTION_ASSERT_SVH
`define CYLINDER_POINT_PROJECTION_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CPP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cylinder_point_projection: invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CPP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cylinder_point_projection: implication violated");

`endif

/* sv/cpp_pkg.sv */
// Package with types and constants of the cylinder point projection pipeline.
package cpp_pkg;

  localparam int CoordW = 32;
  localparam int RegW   = 31;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;

  typedef enum logic [1:0] {
    REG_HALF_LENGTH = 2'd0,
    REG_RADIUS      = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    M_PASS  = 2'd0,
    M_SCALE = 2'd1,
    M_AXIS  = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [CoordW:0]          ax;
    logic [CoordW-1:0]        ay;
    logic [CoordW-1:0]        az;
  } pt_t;

  typedef struct packed {
    logic        v;
    pt_t         p;
    logic        outr;
    logic        ins;
    logic [63:0] srem;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic        v;
    pt_t         p;
    logic        ins;
    logic        capx;
    mode_t       mode;
    logic [31:0] n;
    logic [62:0] yprod;
    logic [62:0] zprod;
  } dec_t;

  typedef struct packed {
    logic        v;
    pt_t         p;
    logic        ins;
    logic        capx;
    mode_t       mode;
    logic [31:0] n;
    logic [31:0] yr;
    logic [31:0] ylo;
    logic [31:0] yq;
    logic [31:0] zr;
    logic [31:0] zlo;
    logic [31:0] zq;
  } dv_t;

endpackage

/* sv/cylinder_point_projection.sv */
// Top level of the cylinder point projection pipeline.
//
//  channel | signals                                   | direction
//  input   | in_valid, in_ready, px, py, pz            | item in
//  output  | out_valid, out_ready, qx, qy, qz, is_inside | item out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One item enters per cycle unless the pipeline holds; an item passes the input registers,
// the 32-stage square root, the decision stage, the 32-stage divider and the output register.
// Reset clears all valid bits and both registers; the pipeline is empty after it.
// When out_valid is high and the output is not taken, the whole pipeline holds and in_ready drops.
module cylinder_point_projection (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [cpp_pkg::CoordW-1:0] px,
  input  logic signed [cpp_pkg::CoordW-1:0] py,
  input  logic signed [cpp_pkg::CoordW-1:0] pz,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [cpp_pkg::CoordW-1:0] qx,
  output logic signed [cpp_pkg::CoordW-1:0] qy,
  output logic signed [cpp_pkg::CoordW-1:0] qz,
  output logic                         is_inside,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import cpp_pkg::*;

  `include "cylinder_point_projection_assert.svh"

  logic [RegW-1:0] half_length;
  logic [RegW-1:0] radius;
  logic            en;
  logic            va;
  pt_t             pa;
  logic            vb;
  pt_t             pb;
  logic [63:0]     ysq;
  logic [63:0]     zsq;
  logic [61:0]     r2;
  sq_t             sq [0:SqrtSteps];
  dec_t            dc;
  dv_t             dv [0:DivSteps];
  logic [32:0]     qx_mag;

  logic [31:0]     n_w;
  logic            within_x;
  logic            capsel;
  logic [63:0]     ydiv;
  logic [63:0]     zdiv;
  logic [CoordW:0] ax_w;
  logic [CoordW:0] ay_w;
  logic [CoordW:0] az_w;
  logic signed [CoordW-1:0] cap;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= '0;
      radius      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_LENGTH: half_length <= cfg_data[RegW-1:0];
        REG_RADIUS:      radius      <= cfg_data[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ax_w = px[CoordW-1] ? (33'd0 - {px[CoordW-1], px}) : {1'b0, px};
    ay_w = py[CoordW-1] ? (33'd0 - {py[CoordW-1], py}) : {1'b0, py};
    az_w = pz[CoordW-1] ? (33'd0 - {pz[CoordW-1], pz}) : {1'b0, pz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa.x  <= px;
      pa.y  <= py;
      pa.z  <= pz;
      pa.ax <= ax_w;
      pa.ay <= ay_w[31:0];
      pa.az <= az_w[31:0];
      pb    <= pa;
      ysq   <= {32'd0, pa.ay} * {32'd0, pa.ay};
      zsq   <= {32'd0, pa.az} * {32'd0, pa.az};
      r2    <= {31'd0, radius} * {31'd0, radius};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].v <= 1'b0;
    end else if (en) begin
      sq[0].v    <= vb;
      sq[0].p    <= pb;
      sq[0].srem <= ysq + zsq;
      sq[0].outr <= (ysq + zsq) > {2'b00, r2};
      sq[0].ins  <= (pb.ax < {2'b00, half_length}) && !((ysq + zsq) > {2'b00, r2});
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [35:0] r4;
    logic [35:0] trial;
    logic        ge;
    assign r4    = {sq[k].rem, sq[k].srem[63:62]};
    assign trial = {2'b00, sq[k].root, 2'b01};
    assign ge    = r4 >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].v <= 1'b0;
      end else if (en) begin
        sq[k+1].v    <= sq[k].v;
        sq[k+1].p    <= sq[k].p;
        sq[k+1].outr <= sq[k].outr;
        sq[k+1].ins  <= sq[k].ins;
        sq[k+1].srem <= {sq[k].srem[61:0], 2'b00};
        sq[k+1].rem  <= ge ? 34'(r4 - trial) : r4[33:0];
        sq[k+1].root <= {sq[k].root[30:0], ge};
      end
    end
  end

  assign n_w      = sq[SqrtSteps].root;
  assign within_x = sq[SqrtSteps].p.ax <= {2'b00, half_length};
  assign capsel   = ({3'b000, half_length} + {2'b00, n_w})
                    < ({3'b000, radius} + {1'b0, sq[SqrtSteps].p.ax});

  always_ff @(posedge clk) begin
    if (rst) begin
      dc.v <= 1'b0;
    end else if (en) begin
      dc.v     <= sq[SqrtSteps].v;
      dc.p     <= sq[SqrtSteps].p;
      dc.ins   <= sq[SqrtSteps].ins;
      dc.n     <= n_w;
      dc.capx  <= !within_x || (!sq[SqrtSteps].outr && capsel);
      if (sq[SqrtSteps].outr || (within_x && !capsel && n_w != '0)) begin
        dc.mode <= M_SCALE;
      end else if (within_x && !capsel) begin
        dc.mode <= M_AXIS;
      end else begin
        dc.mode <= M_PASS;
      end
      dc.yprod <= {31'd0, sq[SqrtSteps].p.ay} * {32'd0, radius};
      dc.zprod <= {31'd0, sq[SqrtSteps].p.az} * {32'd0, radius};
    end
  end

  assign ydiv = {1'b0, dc.yprod} + {33'd0, dc.n[31:1]};
  assign zdiv = {1'b0, dc.zprod} + {33'd0, dc.n[31:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (en) begin
      dv[0].v    <= dc.v;
      dv[0].p    <= dc.p;
      dv[0].ins  <= dc.ins;
      dv[0].capx <= dc.capx;
      dv[0].mode <= dc.mode;
      dv[0].n    <= dc.n;
      dv[0].yr   <= ydiv[63:32];
      dv[0].ylo  <= ydiv[31:0];
      dv[0].yq   <= '0;
      dv[0].zr   <= zdiv[63:32];
      dv[0].zlo  <= zdiv[31:0];
      dv[0].zq   <= '0;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [32:0] ty;
    logic [32:0] tz;
    logic        gy;
    logic        gz;
    assign ty = {dv[k].yr, dv[k].ylo[31]};
    assign tz = {dv[k].zr, dv[k].zlo[31]};
    assign gy = ty >= {1'b0, dv[k].n};
    assign gz = tz >= {1'b0, dv[k].n};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].v <= 1'b0;
      end else if (en) begin
        dv[k+1].v    <= dv[k].v;
        dv[k+1].p    <= dv[k].p;
        dv[k+1].ins  <= dv[k].ins;
        dv[k+1].capx <= dv[k].capx;
        dv[k+1].mode <= dv[k].mode;
        dv[k+1].n    <= dv[k].n;
        dv[k+1].yr   <= gy ? 32'(ty - {1'b0, dv[k].n}) : ty[31:0];
        dv[k+1].zr   <= gz ? 32'(tz - {1'b0, dv[k].n}) : tz[31:0];
        dv[k+1].ylo  <= {dv[k].ylo[30:0], 1'b0};
        dv[k+1].zlo  <= {dv[k].zlo[30:0], 1'b0};
        dv[k+1].yq   <= {dv[k].yq[30:0], gy};
        dv[k+1].zq   <= {dv[k].zq[30:0], gz};
      end
    end
  end

  assign cap = dv[DivSteps].p.x[CoordW-1] ? (32'd0 - {1'b0, half_length})
                                          : {1'b0, half_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DivSteps].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx        <= dv[DivSteps].capx ? cap : dv[DivSteps].p.x;
      is_inside <= dv[DivSteps].ins;
      case (dv[DivSteps].mode)
        M_SCALE: begin
          qy <= dv[DivSteps].p.y[CoordW-1] ? (32'd0 - dv[DivSteps].yq) : dv[DivSteps].yq;
          qz <= dv[DivSteps].p.z[CoordW-1] ? (32'd0 - dv[DivSteps].zq) : dv[DivSteps].zq;
        end
        M_AXIS: begin
          qy <= {1'b0, radius};
          qz <= '0;
        end
        default: begin
          qy <= dv[DivSteps].p.y;
          qz <= dv[DivSteps].p.z;
        end
      endcase
    end
  end

  assign qx_mag = qx[CoordW-1] ? (33'd0 - {qx[CoordW-1], qx}) : {1'b0, qx};

  // The square root remainder never exceeds twice the root.
  `CPP_ASSERT_IMPL(a_sqrt_floor, sq[SqrtSteps].v,
                   sq[SqrtSteps].rem <= {1'b0, sq[SqrtSteps].root, 1'b0})
  // A scaled coordinate never lands beyond the radius.
  `CPP_ASSERT_IMPL(a_scale_bound, dv[DivSteps].v && dv[DivSteps].mode == M_SCALE,
                   dv[DivSteps].yq <= {1'b0, radius} && dv[DivSteps].zq <= {1'b0, radius})
  // An inside point keeps its projected X within the caps.
  `CPP_ASSERT_IMPL(a_inside_x, out_valid && is_inside, qx_mag <= {2'b00, half_length})
  // The input side is ready whenever the output stage is empty.
  `CPP_ASSERT_ALWAYS(a_ready_empty, out_valid || in_ready)

endmodule

/* tb/cylinder_point_projection_checker.sv */
// Checker that predicts and compares projected points of the cylinder pipeline.
module cylinder_point_projection_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] px,
  input  logic [31:0] py,
  input  logic [31:0] pz,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] qx,
  input  logic [31:0] qy,
  input  logic [31:0] qz,
  input  logic        is_inside,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpp_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ins;
  } proj_t;

  logic [30:0] half_len;
  logic [30:0] rad;
  proj_t projections[$];

  assign pending = projections.size();

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] onto_radius(logic signed [63:0] c,
                                                     logic [63:0] r, logic [63:0] n);
    logic [63:0] m;
    m = ((c < 0 ? -c : c) * r + (n >> 1)) / n;
    return c < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic proj_t project(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    proj_t p;
    logic signed [63:0] x, y, z, cap, qxv, qyv, qzv;
    logic [63:0] ax, ay, az, h, r, s, r2, n;
    logic within_x;
    x = {{32{ix[31]}}, ix};
    y = {{32{iy[31]}}, iy};
    z = {{32{iz[31]}}, iz};
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    h = half_len;
    r = rad;
    s = ay * ay + az * az;
    r2 = r * r;
    n = root_floor(s);
    cap = x < 0 ? -$signed(h) : $signed(h);
    qxv = x;
    qyv = y;
    qzv = z;
    within_x = 1;
    p.ins = (ax < h) && (s <= r2);
    if (ax > h) begin
      qxv = cap;
      within_x = 0;
    end
    if (s > r2) begin
      qyv = onto_radius(y, r, n);
      qzv = onto_radius(z, r, n);
    end else if (within_x) begin
      if ($signed(h) - $signed(ax) < $signed(r) - $signed(n)) begin
        qxv = cap;
      end else if (n == 0) begin
        qyv = r;
        qzv = 0;
      end else begin
        qyv = onto_radius(y, r, n);
        qzv = onto_radius(z, r, n);
      end
    end
    p.x = qxv[31:0];
    p.y = qyv[31:0];
    p.z = qzv[31:0];
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    proj_t e;
    if (rst) begin
      half_len <= '0;
      rad <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HALF_LENGTH) half_len <= cfg_data[30:0];
        else if (cfg_index == REG_RADIUS) rad <= cfg_data[30:0];
      end
      if (in_valid && in_ready) projections.push_back(project(px, py, pz));
      if (out_valid && out_ready) begin
        if (projections.size() == 0) begin
          report("unexpected item", qx, '0);
        end else begin
          e = projections.pop_front();
          if (qx !== e.x) report("qx", qx, e.x);
          if (qy !== e.y) report("qy", qy, e.y);
          if (qz !== e.z) report("qz", qz, e.z);
          if (is_inside !== e.ins)
            report("is_inside", {31'd0, is_inside}, {31'd0, e.ins});
        end
      end
    end
  end
endmodule

/* tb/cylinder_point_projection_test.sv */
// Top of the cylinder point projection testbench: stimulus, stalls and verdict.
module cylinder_point_projection_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] px = 0, py = 0, pz = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] qx, qy, qz;
  logic is_inside;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_HALF_LENGTH;
  logic [31:0] cfg_data = 0;
  int err_count;
  int pending;
  bit hold_off = 0;

  always #10 clk = ~clk;

  cylinder_point_projection dut (.*);
  cylinder_point_projection_checker chk (.*);

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int g;
    in_valid <= 1;
    px <= x;
    py <= y;
    pz <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] coord(int h, int r);
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: return $urandom();
      2: return $urandom_range(0, 2 * h) - h;
      3: return h + $urandom_range(0, 3) - 1;
      4: return -h + $urandom_range(0, 3) - 1;
      5: return $urandom_range(0, 2) - 1;
      6: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $urandom_range(0, 2 * r) - r;
    endcase
  endfunction

  initial begin
    int h, r, m, phase;
    int dims[4];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_point(0, 0, 0, 0);
    settle();
    write_reg(REG_HALF_LENGTH, 32'h7fff_ffff);
    write_reg(REG_RADIUS, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_point(0, 0, 0, 0);
    settle();
    write_reg(REG_HALF_LENGTH, 32'h0005_0000);
    write_reg(REG_RADIUS, 32'h0003_0000);
    send_point(32'h0005_0000, 32'h0001_0000, 0, 0);
    send_point(32'hfffb_0000, 0, 0, 0);
    send_point(32'h0000_1000, 0, 0, 0);
    send_point(32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 0);
    send_point(32'h0010_0000, 32'h0010_0000, 32'hfff0_0000, 0);
    send_point(32'h8000_0000, 32'h0001_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0003_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0000_0001, 32'hffff_ffff, 0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    // Fill the pipeline while the output is held off.
    hold_off = 1;
    for (int i = 0; i < 100; i++) send_point(coord(5 << 16, 3 << 16), coord(1, 3 << 16),
                                             coord(1, 3 << 16), 0);
    settle();
    dims = '{0, 1 << 16, 1 << 24, 32'h7fff_ffff};
    for (phase = 0; phase < 8; phase++) begin
      h = (phase < 4) ? dims[phase] : $urandom_range(1, 32'h00ff_ffff);
      r = (phase < 4) ? dims[3 - phase] : $urandom_range(1, 32'h00ff_ffff);
      write_reg(REG_HALF_LENGTH, h);
      write_reg(REG_RADIUS, r);
      for (m = 0; m < 130; m++)
        send_point(coord(h, r), coord(h, r), coord(h, r), 1);
      settle();
    end
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int g;
    @(negedge clk);
    while (!hold_off) begin
      g = gap_len();
      out_ready <= (g == 0) || ($urandom_range(0, 1) == 1);
      @(negedge clk);
    end
    out_ready <= 0;
    repeat (300) @(negedge clk);
    forever begin
      g = gap_len();
      if (g == 0) begin
        out_ready <= 1;
        @(negedge clk);
      end else begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
